### src/configurable_crc_engine_core_macros.svh
// Assertion macros for the configurable CRC engine
`ifndef CONFIGURABLE_CRC_ENGINE_CORE_MACROS_SVH
`define CONFIGURABLE_CRC_ENGINE_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define CCRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ccrc check failed: lbl");

// next-cycle implication, checked out of reset
`define CCRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccrc check failed: lbl");

`endif

### src/ccrc_pkg.sv
// Shared types, codes and bit helpers for the configurable CRC engine
`timescale 1ns / 1ps

package ccrc_pkg;

  localparam int CRC_W      = 32;
  localparam int CFG_ADDR_W = 3;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_SEL = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_POLY      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SEED      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REFLECT   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_FINAL_XOR = 3'd4;

  // width codes; the unused code behaves as 32 bit
  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;

  localparam logic [1:0]       RST_WIDTH_SEL = WSEL_32;
  localparam logic [CRC_W-1:0] RST_POLY      = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] RST_SEED      = 32'hFFFF_FFFF;
  localparam logic             RST_REFLECT   = 1'b1;
  localparam logic [CRC_W-1:0] RST_FINAL_XOR = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]       width_sel;
    logic [CRC_W-1:0] poly;
    logic [CRC_W-1:0] seed;
    logic             reflect;
    logic [CRC_W-1:0] final_xor;
  } cfg_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [CRC_W-1:0] rev32(input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int i = 0; i < CRC_W; i++) begin
      r[i] = v[CRC_W-1-i];
    end
    return r;
  endfunction

endpackage

### src/ccrc_cfg_regs.sv
// Configuration register bank of the configurable CRC engine
`timescale 1ns / 1ps

module ccrc_cfg_regs
  import ccrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CRC_W-1:0]      cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_sel <= RST_WIDTH_SEL;
      cfg_r.poly      <= RST_POLY;
      cfg_r.seed      <= RST_SEED;
      cfg_r.reflect   <= RST_REFLECT;
      cfg_r.final_xor <= RST_FINAL_XOR;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WIDTH_SEL: cfg_r.width_sel <= cfg_wdata[1:0];
        REG_POLY:      cfg_r.poly      <= cfg_wdata;
        REG_SEED:      cfg_r.seed      <= cfg_wdata;
        REG_REFLECT:   cfg_r.reflect   <= cfg_wdata[0];
        REG_FINAL_XOR: cfg_r.final_xor <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### src/ccrc_fold.sv
// Byte-parallel CRC fold and result finishing for widths 8, 16 and 32
`timescale 1ns / 1ps

module ccrc_fold
  import ccrc_pkg::*;
(
  input  cfg_t             cfg,
  input  logic [CRC_W-1:0] crc_cur,
  input  logic [7:0]       data_byte,
  input  logic             first_byte,
  output logic [CRC_W-1:0] crc_nxt,
  output logic [CRC_W-1:0] crc_result
);

  logic [CRC_W-1:0] mask;
  logic [CRC_W-1:0] top;
  logic [CRC_W-1:0] byte_in;
  logic [CRC_W-1:0] poly;
  logic [CRC_W-1:0] r;
  logic [CRC_W-1:0] rev_w;
  logic [7:0]       b;

  always_comb begin
    b = cfg.reflect ? rev8(data_byte) : data_byte;
    unique case (cfg.width_sel)
      WSEL_8: begin
        mask    = 32'h0000_00FF;
        top     = 32'h0000_0080;
        byte_in = {24'd0, b};
      end
      WSEL_16: begin
        mask    = 32'h0000_FFFF;
        top     = 32'h0000_8000;
        byte_in = {16'd0, b, 8'd0};
      end
      default: begin
        mask    = 32'hFFFF_FFFF;
        top     = 32'h8000_0000;
        byte_in = {b, 24'd0};
      end
    endcase
    poly = cfg.poly & mask;
    r    = (first_byte ? cfg.seed : crc_cur) & mask;
    r    = r ^ byte_in;
    for (int i = 0; i < 8; i++) begin
      if ((r & top) != '0) begin
        r = ((r << 1) ^ poly) & mask;
      end else begin
        r = (r << 1) & mask;
      end
    end
    crc_nxt = r;
    // reflect over the active width
    unique case (cfg.width_sel)
      WSEL_8:  rev_w = rev32(r) >> 24;
      WSEL_16: rev_w = rev32(r) >> 16;
      default: rev_w = rev32(r);
    endcase
    crc_result = ((cfg.reflect ? rev_w : r) ^ cfg.final_xor) & mask;
  end

endmodule

### src/configurable_crc_engine_core.sv
// Top level of the configurable CRC engine: stream ports, pipeline and checks
//
// Usage:
//   in_*  : message bytes. in_tdata[7:0] is the byte, in_tuser marks the
//           first byte of a message (reseeds the CRC), in_tlast the last one.
//   out_* : one item per message, out_tdata[31:0] is the finished CRC,
//           zero-extended for 8 and 16 bit widths.
//   cfg_* : write enable, register index, data; write only while idle.
// Throughput: one byte per cycle while no last byte waits for the result
//   register (see Stall). The byte is held in an input register, the
//   eight-bit fold and finishing run combinationally after it, and the
//   running CRC, and for a last byte the result register, load as the byte
//   leaves the input register; out_tvalid then shows the message's CRC.
// Reset (rst_n low, synchronous): configuration returns to CRC-32 defaults,
//   the running CRC clears to zero, both pipeline registers empty.
// Stall: a held result waits in the output register; bytes without a last
//   mark keep flowing, and a last byte waits in the input register until
//   the result register frees, which drops in_tready.
`timescale 1ns / 1ps
`include "configurable_crc_engine_core_macros.svh"

module configurable_crc_engine_core
  import ccrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,  // [7:0] data_byte
  input  logic                  in_tuser,  // [0] first_byte
  input  logic                  in_tlast,  // last_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [CRC_W-1:0]      out_tdata, // [31:0] crc_value
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CRC_W-1:0]      cfg_wdata
);

  cfg_t             cfg;
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_first_r;
  logic             s1_last_r;
  logic [CRC_W-1:0] crc_r;
  logic [CRC_W-1:0] crc_nxt;
  logic [CRC_W-1:0] crc_result;
  logic             out_valid_r;
  logic [CRC_W-1:0] out_data_r;
  logic             out_free;
  logic             s1_adv;

  ccrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ccrc_fold u_fold (
    .cfg        (cfg),
    .crc_cur    (crc_r),
    .data_byte  (s1_byte_r),
    .first_byte (s1_first_r),
    .crc_nxt    (crc_nxt),
    .crc_result (crc_result)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata;
      s1_first_r <= in_tuser;
      s1_last_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
    end else if (s1_adv) begin
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_data_r <= crc_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `CCRC_ASSERT_NOW(a_empty_stage_ready, !s1_valid_r, in_tready)

  `CCRC_ASSERT_NEXT(a_last_waits_for_slot,
    s1_valid_r && s1_last_r && out_valid_r && !out_tready,
    s1_valid_r && $stable(crc_r))

  `CCRC_ASSERT_NEXT(a_result_loaded,
    s1_adv && s1_last_r,
    out_valid_r && out_data_r == $past(crc_result))

endmodule
